// ===== hdl/kv_cache_slot_addresser_defines.svh =====
// Assertion macros for the kv cache slot addresser.
// Uses the clk and rst names of the module that includes it.
`ifndef KV_CACHE_SLOT_ADDRESSER_DEFINES_SVH
`define KV_CACHE_SLOT_ADDRESSER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define KVSA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define KVSA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/kvsa_pkg.sv =====
// Shared widths, codes and structs of the kv cache slot addresser.
// No dependencies; imported by kv_cache_slot_addresser and kvsa_core.
package kvsa_pkg;

  localparam int ADDR_W     = 37;
  localparam int POS_W      = 17;
  localparam int TOKPOS_W   = 16;
  localparam int LAYER_W    = 6;
  localparam int VEC_W      = 16;
  localparam int ACC_W      = 38;
  localparam int MODE_W     = 2;
  localparam int STATUS_W   = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  localparam int DEF_MAX_LAYERS = 64;
  localparam int DEF_MAX_TOKENS = 65536;

  localparam logic [MODE_W-1:0] MODE_APPEND     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_READ_KEY   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ_VALUE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_CLEAR      = 2'd3;

  localparam logic [STATUS_W-1:0] STATUS_OK           = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_BAD_LAYER    = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOT_SEQ      = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_FULL         = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_NOT_RETAINED = 3'd4;
  localparam logic [STATUS_W-1:0] STATUS_BAD_CFG      = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_LAYER_COUNT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KV_HEADS      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAD_WIDTH    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_CONTEXT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SLIDING = 3'd5;

  localparam logic [6:0]       RST_LAYER_COUNT   = 7'd1;
  localparam logic [6:0]       RST_KV_HEADS      = 7'd1;
  localparam logic [8:0]       RST_HEAD_WIDTH    = 9'd1;
  localparam logic [POS_W-1:0] RST_MAX_CONTEXT   = 17'd65536;
  localparam logic [POS_W-1:0] RST_WINDOW_SIZE   = 17'd128;
  localparam logic             RST_FIRST_SLIDING = 1'b1;

  localparam logic [6:0] LIMIT_KV_HEADS   = 7'd64;
  localparam logic [8:0] LIMIT_HEAD_WIDTH = 9'd256;

  // One address job handed to the arithmetic sequencer.
  typedef struct packed {
    logic [TOKPOS_W-1:0] pos;
    logic [POS_W-1:0]    window;
    logic [POS_W-1:0]    max_ctx;
    logic                slides;
    logic [LAYER_W-1:0]  nslide;
    logic [LAYER_W-1:0]  nfull;
    logic [VEC_W-1:0]    vec;
    logic                rd_value;
  } kvsa_job_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [ADDR_W-1:0] addr;
  } kvsa_core_res_t;

endpackage

// ===== hdl/kv_cache_slot_addresser.sv =====
// Top level of the kv cache slot addresser: config registers, position table,
// request checks and response register. Depends on kvsa_pkg, kvsa_ram, kvsa_core.
//
// channel  direction  handshake             payload
// req      in         req_valid/req_stall   mode, layer_index, token_position
// rsp      out        rsp_valid/rsp_stall   status, word_address, next_token,
//                                           oldest_retained
// cfg      in         cfg_valid/cfg_ready   cfg_index, cfg_data
//
// Items are handled one at a time: req_stall is high until the result is in the
// response register. Clear and rejected requests skip kvsa_core; the others run
// the 16-step window modulo (sliding layers only) and the shift-add products there.
// A waiting response holds an item back only when its result is ready first.
// Synchronous reset loads the register defaults and marks all layers empty.
// cfg_ready is always high.
`include "kv_cache_slot_addresser_defines.svh"

module kv_cache_slot_addresser
  import kvsa_pkg::*;
#(
  parameter int MAX_LAYERS = DEF_MAX_LAYERS,
  parameter int MAX_TOKENS = DEF_MAX_TOKENS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  logic [MODE_W-1:0]     mode,
  input  logic [LAYER_W-1:0]    layer_index,
  input  logic [TOKPOS_W-1:0]   token_position,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output logic [STATUS_W-1:0]   status,
  output logic [ADDR_W-1:0]     word_address,
  output logic [POS_W-1:0]      next_token,
  output logic [POS_W-1:0]      oldest_retained,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int LIDX_W = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOOK = 2'd1;
  localparam logic [1:0] ST_CALC = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  // Configuration registers
  logic [6:0]       layer_count;
  logic [6:0]       kv_heads;
  logic [8:0]       head_width;
  logic [POS_W-1:0] max_context;
  logic [POS_W-1:0] window_size;
  logic             first_is_sliding;

  logic [1:0]            state;
  logic [MAX_LAYERS-1:0] valid_bits;
  logic [MODE_W-1:0]     mode_q;
  logic [LAYER_W-1:0]    layer_q;
  logic [TOKPOS_W-1:0]   pos_q;
  logic [STATUS_W-1:0]   status_q;
  logic [ADDR_W-1:0]     addr_q;
  logic [POS_W-1:0]      next_q;
  logic [POS_W-1:0]      oldest_q;

  logic                  req_acc;
  logic                  cfg_ok;
  logic [LIDX_W-1:0]     idx;
  logic [POS_W-1:0]      ram_rdata;
  logic                  ram_we;
  logic [POS_W-1:0]      cur;
  logic [POS_W-1:0]      cur_inc;
  logic [POS_W-1:0]      cap;
  logic [POS_W-1:0]      begin_pos;
  logic [POS_W-1:0]      pos17;
  logic [POS_W-1:0]      nxt;
  logic [POS_W-1:0]      oldest;
  logic                  slides;
  logic                  is_append;
  logic                  is_read;
  logic                  bad_layer;
  logic [STATUS_W-1:0]   chk_status;
  logic                  good;
  logic [LAYER_W-1:0]    nslide;
  logic [LAYER_W-1:0]    nfull;
  logic [VEC_W-1:0]      vec;
  kvsa_job_t             job;
  kvsa_core_res_t        core_res;

  assign req_acc   = req_valid && !req_stall;
  assign req_stall = (state != ST_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      layer_count      <= RST_LAYER_COUNT;
      kv_heads         <= RST_KV_HEADS;
      head_width       <= RST_HEAD_WIDTH;
      max_context      <= RST_MAX_CONTEXT;
      window_size      <= RST_WINDOW_SIZE;
      first_is_sliding <= RST_FIRST_SLIDING;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_LAYER_COUNT:   layer_count      <= cfg_data[6:0];
        CFG_KV_HEADS:      kv_heads         <= cfg_data[6:0];
        CFG_HEAD_WIDTH:    head_width       <= cfg_data[8:0];
        CFG_MAX_CONTEXT:   max_context      <= cfg_data;
        CFG_WINDOW_SIZE:   window_size      <= cfg_data;
        CFG_FIRST_SLIDING: first_is_sliding <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  assign cfg_ok = (layer_count != '0) && (kv_heads != '0) && (head_width != '0) &&
                  (max_context != '0) && (window_size != '0) &&
                  (32'(layer_count) <= 32'(MAX_LAYERS)) &&
                  (kv_heads <= LIMIT_KV_HEADS) && (head_width <= LIMIT_HEAD_WIDTH) &&
                  (32'(max_context) <= 32'(MAX_TOKENS)) &&
                  (window_size <= max_context);

  // Position table: an entry with its valid bit clear reads as zero.
  kvsa_ram #(.WIDTH(POS_W), .DEPTH(MAX_LAYERS)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx),
    .wdata (cur_inc),
    .raddr (LIDX_W'(layer_index)),
    .rdata (ram_rdata)
  );

  assign idx       = LIDX_W'(layer_q);
  assign cur       = valid_bits[idx] ? ram_rdata : '0;
  assign cur_inc   = cur + POS_W'(1);
  assign pos17     = POS_W'(pos_q);
  assign is_append = (mode_q == MODE_APPEND);
  assign is_read   = (mode_q == MODE_READ_KEY) || (mode_q == MODE_READ_VALUE);
  assign slides    = first_is_sliding ? !layer_q[0] : layer_q[0];
  assign cap       = slides ? window_size : max_context;
  assign begin_pos = (cur > cap) ? (cur - cap) : '0;
  assign bad_layer = ({1'b0, layer_q} >= layer_count);

  always_comb begin
    chk_status = STATUS_OK;
    if (is_append) begin
      if (pos17 != cur) begin
        chk_status = STATUS_NOT_SEQ;
      end else if (pos17 >= max_context) begin
        chk_status = STATUS_FULL;
      end
    end else if (is_read) begin
      if ((pos17 >= cur) || (pos17 < begin_pos)) begin
        chk_status = STATUS_NOT_RETAINED;
      end
    end
  end

  assign good   = cfg_ok && !bad_layer && (chk_status == STATUS_OK);
  assign nxt    = (good && is_append) ? cur_inc : cur;
  assign oldest = (nxt > cap) ? (nxt - cap) : '0;
  assign ram_we = (state == ST_LOOK) && good && is_append;

  // Layers before this one, split by kind.
  assign nslide = first_is_sliding ? LAYER_W'((7'(layer_q) + 7'd1) >> 1)
                                   : LAYER_W'(layer_q >> 1);
  assign nfull  = layer_q - nslide;
  assign vec    = VEC_W'(kv_heads) * VEC_W'(head_width);

  assign job.pos      = pos_q;
  assign job.window   = window_size;
  assign job.max_ctx  = max_context;
  assign job.slides   = slides;
  assign job.nslide   = nslide;
  assign job.nfull    = nfull;
  assign job.vec      = vec;
  assign job.rd_value = (mode_q == MODE_READ_VALUE);

  kvsa_core u_core (
    .clk   (clk),
    .rst   (rst),
    .start ((state == ST_LOOK) && good),
    .job   (job),
    .res   (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      rsp_valid  <= 1'b0;
      valid_bits <= '0;
    end else begin
      // Drop a taken response unless the done state reloads it this cycle.
      if (rsp_valid && !rsp_stall && (state != ST_DONE)) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (req_acc) begin
            mode_q  <= mode;
            layer_q <= layer_index;
            pos_q   <= token_position;
            if (mode == MODE_CLEAR) begin
              valid_bits <= '0;
              status_q   <= cfg_ok ? STATUS_OK : STATUS_BAD_CFG;
              addr_q     <= '0;
              next_q     <= '0;
              oldest_q   <= '0;
              state      <= ST_DONE;
            end else begin
              state <= ST_LOOK;
            end
          end
        end
        ST_LOOK: begin
          addr_q <= '0;
          if (!cfg_ok) begin
            status_q <= STATUS_BAD_CFG;
            next_q   <= '0;
            oldest_q <= '0;
          end else if (bad_layer) begin
            status_q <= STATUS_BAD_LAYER;
            next_q   <= '0;
            oldest_q <= '0;
          end else begin
            status_q <= chk_status;
            next_q   <= nxt;
            oldest_q <= oldest;
          end
          if (ram_we) begin
            valid_bits[idx] <= 1'b1;
          end
          state <= good ? ST_CALC : ST_DONE;
        end
        ST_CALC: begin
          if (core_res.done) begin
            addr_q <= core_res.addr;
            state  <= ST_DONE;
          end
        end
        ST_DONE: begin
          // Hold the result until the response register is free.
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid       <= 1'b1;
            status          <= status_q;
            word_address    <= addr_q;
            next_token      <= next_q;
            oldest_retained <= oldest_q;
            state           <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `KVSA_ASSERT_NEXT(a_clear_empties_table, req_acc && (mode == MODE_CLEAR), valid_bits == '0, "clear item left a layer position live")
  `KVSA_ASSERT_NOW(a_busy_blocks_req, core_res.busy, req_stall, "request taken while the sequencer is busy")
  `KVSA_ASSERT_NOW(a_done_in_calc, core_res.done, state == ST_CALC, "sequencer finished outside the calc state")
  `KVSA_ASSERT_NOW(a_rsp_from_done, $rose(rsp_valid), $past(state) == ST_DONE, "response raised without a finished item")

endmodule

// ===== hdl/kvsa_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module kvsa_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/kvsa_alu.sv =====
// Shared add/subtract unit of the address sequencer.
// Carry out on subtract means a >= b. No dependencies.
module kvsa_alu #(
  parameter int W = 38
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic         sub,
  output logic [W-1:0] sum,
  output logic         carry
);

  logic [W-1:0] b_eff;

  assign b_eff = sub ? ~b : b;
  assign {carry, sum} = {1'b0, a} + {1'b0, b_eff} + (W + 1)'(sub);

endmodule

// ===== hdl/kvsa_core.sv =====
// Address sequencer: ring slot by restoring modulo on sliding layers, then
// shift-add products, all through one shared kvsa_alu. Depends on kvsa_pkg and kvsa_alu.
module kvsa_core
  import kvsa_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  kvsa_job_t      job,
  output kvsa_core_res_t res
);

  localparam logic [2:0] C_IDLE = 3'd0;
  localparam logic [2:0] C_MOD  = 3'd1;
  localparam logic [2:0] C_MULS = 3'd2;
  localparam logic [2:0] C_MULF = 3'd3;
  localparam logic [2:0] C_MULV = 3'd4;
  localparam logic [2:0] C_OFS  = 3'd5;
  localparam logic [2:0] C_DONE = 3'd6;

  localparam logic [3:0] CNT_MOD  = 4'(TOKPOS_W - 1);
  localparam logic [3:0] CNT_LAY  = 4'(LAYER_W - 1);
  localparam logic [3:0] CNT_VEC  = 4'(VEC_W - 1);

  logic [2:0]          cst;
  kvsa_job_t           job_q;
  logic [POS_W-1:0]    rem;
  logic [TOKPOS_W-1:0] shq;
  logic [ACC_W-1:0]    acc;
  logic [ACC_W-1:0]    mcand;
  logic [VEC_W-1:0]    mplier;
  logic [3:0]          cnt;

  logic [ACC_W-1:0]    alu_a;
  logic [ACC_W-1:0]    alu_b;
  logic                alu_sub;
  logic [ACC_W-1:0]    alu_sum;
  logic                alu_carry;
  logic [POS_W:0]      mod_t;
  logic [POS_W-1:0]    rem_next;
  logic [ACC_W-1:0]    acc_next;

  kvsa_alu #(.W(ACC_W)) u_alu (
    .a     (alu_a),
    .b     (alu_b),
    .sub   (alu_sub),
    .sum   (alu_sum),
    .carry (alu_carry)
  );

  // Bring down the next dividend bit and trial-subtract the window.
  assign mod_t    = {rem, shq[TOKPOS_W-1]};
  assign rem_next = alu_carry ? alu_sum[POS_W-1:0] : mod_t[POS_W-1:0];
  assign acc_next = mplier[0] ? alu_sum : acc;

  always_comb begin
    alu_a   = acc;
    alu_b   = mcand;
    alu_sub = 1'b0;
    case (cst)
      C_MOD: begin
        alu_a   = ACC_W'(mod_t);
        alu_b   = ACC_W'(job_q.window);
        alu_sub = 1'b1;
      end
      C_OFS: begin
        alu_b = ACC_W'(job_q.vec);
      end
      default: begin
        alu_a = acc;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cst <= C_IDLE;
    end else begin
      unique case (cst)
        C_IDLE: begin
          if (start) begin
            job_q <= job;
            if (job.slides) begin
              rem <= '0;
              shq <= job.pos;
              cnt <= CNT_MOD;
              cst <= C_MOD;
            end else begin
              acc    <= ACC_W'(job.pos);
              mcand  <= ACC_W'(job.window);
              mplier <= VEC_W'(job.nslide);
              cnt    <= CNT_LAY;
              cst    <= C_MULS;
            end
          end
        end
        C_MOD: begin
          rem <= rem_next;
          shq <= shq << 1;
          cnt <= cnt - 4'd1;
          if (cnt == '0) begin
            acc    <= ACC_W'(rem_next);
            mcand  <= ACC_W'(job_q.window);
            mplier <= VEC_W'(job_q.nslide);
            cnt    <= CNT_LAY;
            cst    <= C_MULS;
          end
        end
        C_MULS: begin
          acc    <= acc_next;
          mcand  <= mcand << 1;
          mplier <= mplier >> 1;
          cnt    <= cnt - 4'd1;
          if (cnt == '0) begin
            mcand  <= ACC_W'(job_q.max_ctx);
            mplier <= VEC_W'(job_q.nfull);
            cnt    <= CNT_LAY;
            cst    <= C_MULF;
          end
        end
        C_MULF: begin
          acc    <= acc_next;
          mcand  <= mcand << 1;
          mplier <= mplier >> 1;
          cnt    <= cnt - 4'd1;
          if (cnt == '0) begin
            // Slot count is done: scale by two vectors per slot.
            acc    <= '0;
            mcand  <= {acc_next[ACC_W-2:0], 1'b0};
            mplier <= job_q.vec;
            cnt    <= CNT_VEC;
            cst    <= C_MULV;
          end
        end
        C_MULV: begin
          acc    <= acc_next;
          mcand  <= mcand << 1;
          mplier <= mplier >> 1;
          cnt    <= cnt - 4'd1;
          if (cnt == '0) begin
            cst <= job_q.rd_value ? C_OFS : C_DONE;
          end
        end
        C_OFS: begin
          acc <= alu_sum;
          cst <= C_DONE;
        end
        C_DONE: begin
          cst <= C_IDLE;
        end
        default: begin
          cst <= C_IDLE;
        end
      endcase
    end
  end

  assign res.busy = (cst != C_IDLE);
  assign res.done = (cst == C_DONE);
  assign res.addr = acc[ADDR_W-1:0];

endmodule
